>>> hdl/aodi_pkg.sv
// Shared types and constants for the ADC oversampling averager with deadband IIR filter.
// Used by aodi_upd, aodi_skid and the top level; depends on nothing else.
package aodi_pkg;

  localparam int unsigned SAMPLE_BITS = 12;
  localparam int unsigned CH_W        = 4;
  localparam int unsigned SLOT_W      = 2;
  localparam int unsigned SUM_W       = SAMPLE_BITS + 2;
  localparam int unsigned OV_W        = SUM_W;
  localparam int unsigned FILT_W      = SUM_W;
  localparam int unsigned OUT_W       = SAMPLE_BITS + 1;
  localparam int unsigned GAIN_W      = 16;
  localparam int unsigned SHIFT_W     = 4;
  localparam int unsigned DB_W        = 8;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam int unsigned OV_MAX      = (1 << (SAMPLE_BITS + 1)) - 2;
  localparam int unsigned Q15_SHIFT   = 15;
  localparam int unsigned Q15_HALF    = 1 << 14;

  localparam logic [SLOT_W-1:0] SLOT_FIRST = 2'd0;
  localparam logic [SLOT_W-1:0] SLOT_LAST  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_USE_Q15  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_N  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_Q15 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 2'd3;

  localparam logic                RST_USE_Q15  = 1'b1;
  localparam logic [SHIFT_W-1:0]  RST_SHIFT_N  = 4'd3;
  localparam logic [GAIN_W-1:0]   RST_GAIN_Q15 = 16'd4118;
  localparam logic [DB_W-1:0]     RST_DEADBAND = 8'd2;

  typedef struct packed {
    logic                   use_q15;
    logic [SHIFT_W-1:0]     shift_n;
    logic [GAIN_W-1:0]      gain_q15;
    logic [DB_W-1:0]        deadband;
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0]        channel;
    logic [SLOT_W-1:0]      slot;
    logic [SAMPLE_BITS-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]        out_channel;
    logic [OUT_W-1:0]       oversampled;
    logic [OUT_W-1:0]       filtered_value;
  } out_item_t;

endpackage

>>> hdl/aodi_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Self-contained; holds the per-channel state of the block.
module aodi_ram #(
  parameter int unsigned WIDTH = 14,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // A read of the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/aodi_upd.sv
// Filter update datapath: first-frame load, deadband test, shift or Q15 gain step, and saturation.
// Depends on aodi_pkg for widths, constants and the configuration struct.
module aodi_upd import aodi_pkg::*; (
  input  cfg_t              cfg_i,
  input  logic              started_i,
  input  logic [OV_W-1:0]   ov_i,
  input  logic [FILT_W-1:0] v_i,
  output logic [FILT_W-1:0] value_o
);

  localparam int unsigned ERR_W  = FILT_W + 1;
  localparam int unsigned DLT_W  = ERR_W + 2;
  localparam int unsigned PROD_W = ERR_W + GAIN_W + 1;
  localparam int unsigned NV_W   = DLT_W + 1;

  logic signed [ERR_W-1:0]  err;
  logic signed [ERR_W-1:0]  db_x;
  logic                     in_db;
  logic        [DLT_W-1:0]  rnd;
  logic signed [DLT_W-1:0]  sh_sum;
  logic signed [DLT_W-1:0]  d_shift;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] q_sum;
  logic signed [DLT_W-1:0]  d_q15;
  logic signed [DLT_W-1:0]  delta;
  logic signed [NV_W-1:0]   nv;

  always_comb begin
    err  = $signed({1'b0, ov_i}) - $signed({1'b0, v_i});
    db_x = $signed(ERR_W'(cfg_i.deadband));
    in_db = (err <= db_x) && (err >= -db_x);

    // A shift of zero has no rounding term, so the filter jumps to the new value.
    rnd     = (cfg_i.shift_n == '0) ? '0 : (DLT_W'(1) << (cfg_i.shift_n - SHIFT_W'(1)));
    sh_sum  = DLT_W'(err) + $signed(rnd);
    d_shift = sh_sum >>> cfg_i.shift_n;

    prod  = err * $signed({1'b0, cfg_i.gain_q15});
    q_sum = prod + $signed(PROD_W'(Q15_HALF));
    d_q15 = DLT_W'(q_sum >>> Q15_SHIFT);

    delta = cfg_i.use_q15 ? d_q15 : d_shift;
    nv    = $signed(NV_W'(v_i)) + NV_W'(delta);

    if (!started_i) begin
      value_o = ov_i;
    end else if (in_db) begin
      value_o = v_i;
    end else if (nv < 0) begin
      value_o = '0;
    end else if (nv > $signed(NV_W'(OV_MAX))) begin
      value_o = FILT_W'(OV_MAX);
    end else begin
      value_o = nv[FILT_W-1:0];
    end
  end

endmodule

>>> hdl/aodi_skid.sv
// Two-entry output buffer: an output register and a skid register behind it.
// Depends on aodi_pkg for the result struct.
module aodi_skid import aodi_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      r_valid_i,
  input  out_item_t r_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o,
  output logic      full_o
);

  logic      out_valid_q;
  logic      skid_valid_q;
  out_item_t out_item_q;
  out_item_t skid_item_q;
  logic      out_take;

  assign out_take = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || out_take) begin
      out_valid_q <= r_valid_i;
    end else if (r_valid_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_item_q <= skid_item_q;
      end
    end else if (!out_valid_q || out_take) begin
      if (r_valid_i) begin
        out_item_q <= r_item_i;
      end
    end else if (r_valid_i) begin
      skid_item_q <= r_item_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;
  assign full_o      = skid_valid_q;

endmodule

>>> hdl/adc_oversample_deadband_iir_top.sv
// ADC oversampling averager with deadband IIR low-pass filter, top level.
// Depends on aodi_pkg, aodi_ram, aodi_upd and aodi_skid.
//
// Usage:
// Samples enter on the input channel, each tagged with its channel and its slot in a
// four-sample frame. Slot 0 starts a new frame sum; slots 1 to 3 add to it. On slot 3
// the block emits one result: the channel, (sum + 1) >> 1 and the updated filter value.
// Samples of a channel at or above CHANNELS are dropped without a result.
// One sample is taken every cycle while the input is not stalled, for any mix of channels.
// Each result passes the first stage, the filter stage and the output register in turn.
// Frame sums and filter values live in two RAMs with a registered read port;
// results of the two transactions just ahead on the same channel are forwarded around them.
// Configuration must be written through the write port only while no transaction is in
// flight; the block does not enforce this. Reset restores the register defaults and marks
// every filter as not started; the RAM contents stay undefined and need no clearing pass,
// since a sum is written by slot 0 and a filter value by its first frame before either is used.
// The output has a register and a skid register. When the receiver stalls, the
// pipeline keeps running until the skid register fills; then the input stalls.
module adc_oversample_deadband_iir_top import aodi_pkg::*; #(
  parameter int unsigned CHANNELS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_item_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned EXT_W = (IDX_W > CH_W) ? IDX_W : CH_W;

  cfg_t cfg_q;

  logic              adv;
  logic              skid_full;
  logic              accept;
  logic              in_range;
  logic [EXT_W-1:0]  in_ch_ext;
  logic [IDX_W-1:0]  in_idx;

  // First stage: RAM data arrives.
  logic                   s1_valid_q;
  logic [IDX_W-1:0]       s1_idx_q;
  logic [CH_W-1:0]        s1_ch_q;
  logic [SLOT_W-1:0]      s1_slot_q;
  logic [SAMPLE_BITS-1:0] s1_smp_q;

  // Second stage: filter update.
  logic                   s2_valid_q;
  logic [IDX_W-1:0]       s2_idx_q;
  logic [CH_W-1:0]        s2_ch_q;
  logic [OV_W-1:0]        s2_ov_q;
  logic [FILT_W-1:0]      s2_filt_q;

  // Last write of each RAM, kept in a register for forwarding.
  logic                   fw_valid_q;
  logic [IDX_W-1:0]       fw_idx_q;
  logic [SUM_W-1:0]       fw_sum_q;
  logic                   wb_valid_q;
  logic [IDX_W-1:0]       wb_idx_q;
  logic [FILT_W-1:0]      wb_val_q;

  logic [CHANNELS-1:0]    started_q;

  logic [SUM_W-1:0]       sum_rdata;
  logic [FILT_W-1:0]      filt_rdata;
  logic [SUM_W-1:0]       sum_old;
  logic [SUM_W-1:0]       sum_new;
  logic [SUM_W:0]         sum_inc;
  logic [OV_W-1:0]        ov_s1;
  logic [FILT_W-1:0]      filt_s1;
  logic [FILT_W-1:0]      v_s2;
  logic [FILT_W-1:0]      new_val;
  logic                   r_valid;
  out_item_t              r_item;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.use_q15  <= RST_USE_Q15;
      cfg_q.shift_n  <= RST_SHIFT_N;
      cfg_q.gain_q15 <= RST_GAIN_Q15;
      cfg_q.deadband <= RST_DEADBAND;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_USE_Q15:  cfg_q.use_q15  <= cfg_wdata_i[0];
        CFG_SHIFT_N:  cfg_q.shift_n  <= cfg_wdata_i[SHIFT_W-1:0];
        CFG_GAIN_Q15: cfg_q.gain_q15 <= cfg_wdata_i[GAIN_W-1:0];
        CFG_DEADBAND: cfg_q.deadband <= cfg_wdata_i[DB_W-1:0];
      endcase
    end
  end

  // The whole pipeline advances unless the skid register holds a result.
  assign adv        = !skid_full;
  assign in_stall_o = skid_full;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_ch_ext  = EXT_W'(in_item_i.channel);
  assign in_idx     = in_ch_ext[IDX_W-1:0];
  assign in_range   = (32'(in_item_i.channel) < 32'(CHANNELS));

  aodi_ram #(
    .WIDTH (SUM_W),
    .DEPTH (CHANNELS)
  ) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (adv && s1_valid_q),
    .waddr_i (s1_idx_q),
    .wdata_i (sum_new),
    .re_i    (adv),
    .raddr_i (in_idx),
    .rdata_o (sum_rdata)
  );

  aodi_ram #(
    .WIDTH (FILT_W),
    .DEPTH (CHANNELS)
  ) u_filt_ram (
    .clk_i   (clk_i),
    .we_i    (adv && s2_valid_q),
    .waddr_i (s2_idx_q),
    .wdata_i (new_val),
    .re_i    (adv),
    .raddr_i (in_idx),
    .rdata_o (filt_rdata)
  );

  // The RAM read misses the write made in the same cycle; take it from the forward copy.
  always_comb begin
    sum_old = (fw_valid_q && (fw_idx_q == s1_idx_q)) ? fw_sum_q : sum_rdata;
    sum_new = (s1_slot_q == SLOT_FIRST) ? SUM_W'(s1_smp_q) : sum_old + SUM_W'(s1_smp_q);
    sum_inc = {1'b0, sum_new} + (SUM_W + 1)'(1);
    ov_s1   = sum_inc[SUM_W:1];
    filt_s1 = (wb_valid_q && (wb_idx_q == s1_idx_q)) ? wb_val_q : filt_rdata;
    v_s2    = (wb_valid_q && (wb_idx_q == s2_idx_q)) ? wb_val_q : s2_filt_q;
  end

  aodi_upd u_upd (
    .cfg_i     (cfg_q),
    .started_i (started_q[s2_idx_q]),
    .ov_i      (s2_ov_q),
    .v_i       (v_s2),
    .value_o   (new_val)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      fw_valid_q <= 1'b0;
      wb_valid_q <= 1'b0;
      started_q  <= '0;
    end else if (adv) begin
      s1_valid_q <= accept && in_range;
      s2_valid_q <= s1_valid_q && (s1_slot_q == SLOT_LAST);
      fw_valid_q <= s1_valid_q;
      wb_valid_q <= s2_valid_q;
      if (s2_valid_q) begin
        started_q[s2_idx_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_idx_q  <= in_idx;
      s1_ch_q   <= in_item_i.channel;
      s1_slot_q <= in_item_i.slot;
      s1_smp_q  <= in_item_i.sample;
      s2_idx_q  <= s1_idx_q;
      s2_ch_q   <= s1_ch_q;
      s2_ov_q   <= ov_s1;
      s2_filt_q <= filt_s1;
      fw_idx_q  <= s1_idx_q;
      fw_sum_q  <= sum_new;
      wb_idx_q  <= s2_idx_q;
      wb_val_q  <= new_val;
    end
  end

  assign r_valid               = adv && s2_valid_q;
  assign r_item.out_channel    = s2_ch_q;
  assign r_item.oversampled    = s2_ov_q[OUT_W-1:0];
  assign r_item.filtered_value = new_val[OUT_W-1:0];

  aodi_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .r_valid_i   (r_valid),
    .r_item_i    (r_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .full_o      (skid_full)
  );

`ifndef SYNTHESIS
  // A full skid register always sits behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("skid register full while output register empty");

  // A completed frame marks its channel's filter as started.
  a_started_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s2_valid_q) |=> started_q[$past(s2_idx_q)])
    else $error("filter not marked started after its first frame");

  // Every frame sum write is kept for forwarding to the next transaction.
  a_sum_forward: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s1_valid_q) |=> (fw_valid_q && (fw_idx_q == $past(s1_idx_q))))
    else $error("frame sum write not captured for forwarding");

  // While the pipeline is held, the filter stage and its forward copy do not move.
  a_hold_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ($stable(s2_valid_q) && $stable(wb_valid_q) && $stable(started_q)))
    else $error("pipeline state changed while held");
`endif

endmodule
